### sv/nscv_pkg.sv
// nscv_pkg: shared constants, result type and hex digit decode for the
// NMEA sentence checksum verifier. No dependencies.
package nscv_pkg;

    localparam int unsigned LINE_MAX = 256;
    localparam int unsigned LEN_W    = $clog2(LINE_MAX + 1);
    localparam int unsigned OUT_LEN_W = 9;
    localparam int unsigned FAIL_W   = 16;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;

    localparam int unsigned RES_W  = 1 + OUT_LEN_W + FAIL_W;
    localparam int unsigned TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef struct packed {
        logic [FAIL_W-1:0]    fail_count;
        logic [OUT_LEN_W-1:0] sentence_length;
        logic                 checksum_ok;
    } result_t;

    // ASCII hex digit to nibble; anything else reads as zero
    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [3:0] v;
        v = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = 4'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = 4'(b - 8'h37);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = 4'(b - 8'h57);
        end
        return v;
    endfunction

endpackage

### sv/nscv_line_check.sv
// nscv_line_check: per-line checksum state, updated once per accepted beat,
// and the result for a line end. Depends on nscv_pkg.
module nscv_line_check import nscv_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       beat_valid,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output result_t    res
);

    logic [7:0]       running_xor_reg, running_xor_next;
    logic             star_seen_reg, star_seen_next;
    logic [1:0]       digits_reg, digits_next;
    logic [7:0]       rx_sum_reg, rx_sum_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [FAIL_W-1:0] fail_reg, fail_next;

    logic is_end;
    logic is_dollar;
    logic ok;
    logic fail;

    assign is_dollar = (rx_byte == CHAR_DOLLAR);
    assign is_end    = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);

    assign ok   = (len_reg != '0) && star_seen_reg && (digits_reg == 2'd2)
                  && (rx_sum_reg == running_xor_reg);
    assign fail = (len_reg != '0) && !ok;

    always_comb begin
        running_xor_next = running_xor_reg;
        star_seen_next   = star_seen_reg;
        digits_next      = digits_reg;
        rx_sum_next      = rx_sum_reg;
        len_next         = len_reg;
        fail_next        = fail_reg;
        if (beat_valid && !is_dollar) begin
            if (is_end) begin
                if (fail && fail_reg != {FAIL_W{1'b1}}) begin
                    fail_next = fail_reg + 1'b1;
                end
                running_xor_next = '0;
                star_seen_next   = 1'b0;
                digits_next      = '0;
                rx_sum_next      = '0;
                len_next         = '0;
            end else begin
                // overlong line: drop what was held, this byte starts afresh
                if (len_reg >= LEN_W'(LINE_MAX)) begin
                    running_xor_next = '0;
                    star_seen_next   = 1'b0;
                    digits_next      = '0;
                    rx_sum_next      = '0;
                    len_next         = LEN_W'(1);
                    if (rx_byte == CHAR_STAR) begin
                        star_seen_next = 1'b1;
                    end else begin
                        running_xor_next = rx_byte;
                    end
                end else begin
                    len_next = len_reg + 1'b1;
                    if (!star_seen_reg) begin
                        if (rx_byte == CHAR_STAR) begin
                            star_seen_next = 1'b1;
                        end else begin
                            running_xor_next = running_xor_reg ^ rx_byte;
                        end
                    end else if (digits_reg < 2'd2) begin
                        rx_sum_next = {rx_sum_reg[3:0], hex_value(rx_byte)};
                        digits_next = digits_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_xor_reg <= '0;
            star_seen_reg   <= 1'b0;
            digits_reg      <= '0;
            rx_sum_reg      <= '0;
            len_reg         <= '0;
            fail_reg        <= '0;
        end else begin
            running_xor_reg <= running_xor_next;
            star_seen_reg   <= star_seen_next;
            digits_reg      <= digits_next;
            rx_sum_reg      <= rx_sum_next;
            len_reg         <= len_next;
            fail_reg        <= fail_next;
        end
    end

    assign res_valid           = beat_valid && is_end;
    assign res.checksum_ok     = ok;
    assign res.sentence_length = OUT_LEN_W'(len_reg);
    assign res.fail_count      = (fail && fail_reg != {FAIL_W{1'b1}})
                                 ? fail_reg + 1'b1 : fail_reg;

endmodule

### sv/nscv_out_buf.sv
// nscv_out_buf: two-entry result register (output stage plus skid) so
// input ready never waits on the downstream combinationally. Depends on nscv_pkg.
module nscv_out_buf import nscv_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t in_data,
    output logic    in_ready,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_ready
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    out_fire;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign out_fire  = main_valid_reg && out_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (out_fire) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else if (in_valid) begin
                main_next = in_data;
            end else begin
                main_valid_next = 1'b0;
            end
        end else if (in_valid && !skid_valid_reg) begin
            if (!main_valid_reg) begin
                main_next       = in_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = in_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

### sv/nmea_sentence_checksum_verifier.sv
// nmea_sentence_checksum_verifier: top level, joins the line checker and
// the result buffer. Depends on nscv_pkg, nscv_line_check, nscv_out_buf.
//
// Usage
//  - Input stream (s_*): one sentence character per beat in s_tdata.
//    '$' is dropped, CR or LF closes the line. All other bytes are
//    counted; bytes before the first '*' are XORed into the sum, the two
//    after it are taken as hex digits (non-hex reads as zero).
//  - Result stream (m_*): one beat per CR or LF, none for other bytes.
//    m_tdata carries checksum_ok, sentence_length and the saturating
//    fail_count (this line included). Empty lines give ok 0, no count.
//  - A line longer than LINE_MAX characters restarts from the byte that
//    overflows it.
//  - Throughput: one byte per cycle while s_tready is high. The line state is a single
//    register stage updated from the accepted byte.
//  - Result: shown on m_tvalid the cycle after the terminating byte is
//    accepted if the output stage is free; else it waits in the skid.
//  - Stall: results sit in a two-entry buffer; s_tready drops only when
//    both entries are full, so one further line end may arrive while the
//    receiver stalls. Bytes that end no line still need s_tready high.
//  - Reset (aresetn low, synchronous): line state, failure count and the
//    buffer are cleared; s_tready is high on the first cycle after.
module nmea_sentence_checksum_verifier import nscv_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // [0] checksum_ok, [9:1] sentence_length,
                                          // [25:10] fail_count, rest zero
);

    logic    beat;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign beat = s_tvalid && s_tready;

    nscv_line_check u_line_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_valid(beat),
        .rx_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    nscv_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_data  (res),
        .in_ready (s_tready),
        .out_valid(m_tvalid),
        .out_data (out_res),
        .out_ready(m_tready)
    );

    assign m_tdata = TDATA_W'(out_res);

    // a passing line holds at least the star and two digits
    a_ok_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[9:1] >= 9'd3)
        else $error("checksum_ok with too short a sentence");

    // input is held off only while a result is waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // a line end accepted into an empty buffer is offered next cycle
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        beat && (s_tdata == CHAR_LF || s_tdata == CHAR_CR) |=> m_tvalid)
        else $error("line end gave no result");

    // after reset the block is empty and ready
    a_reset_state: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid && s_tready)
        else $error("buffer not clear after reset");

endmodule

### bench/nmea_sentence_checksum_verifier_test.sv
// Self-checking bench for nmea_sentence_checksum_verifier: streams sentence bytes in, checks
// every line-end beat against a cycle-free line predictor kept alongside.
// Depends on nscv_pkg and the verifier RTL only.
module nmea_sentence_checksum_verifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nscv_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1500;  // bytes in the part with idling
    localparam int unsigned CLOSING_ITEMS = 350;  // further bytes, no idling at all
    localparam int unsigned LONG_HOLD = 120;      // receiver hold-off for the stall test
    localparam int unsigned QUIET_LIMIT = 2000;   // cycles with no beat before giving up
    localparam logic [15:0] FAIL_TOP = 16'hFFFF;

    // One input beat, with the line result typed in by hand where it is obvious
    typedef struct packed {
        logic [7:0] c;
        logic       known;
        result_t    want;
    } beat_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;   // [7:0] rx_byte
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;   // [0] checksum_ok, [9:1] sentence_length,
                                   // [25:10] fail_count, rest zero

    nmea_sentence_checksum_verifier dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ---------------------------------------------------------------
    // Line predictor: own copy of the per-line state and the failure
    // tally, advanced once per accepted beat.
    // ---------------------------------------------------------------
    logic [7:0]  line_xor;
    logic        star_hit;
    logic [1:0]  digit_count;
    logic [7:0]  given_sum;
    int unsigned char_count;
    logic [15:0] bad_lines;
    int unsigned longest_line;

    result_t     pending_lines[$];  // line results still owed by the block
    beat_t       beat_notes[$];     // one per beat offered, in order
    int unsigned errors;
    int unsigned lines_checked;
    int unsigned bytes_sent;
    int unsigned long_lines;
    int unsigned sentences;
    bit          gaps_on;
    bit          long_hold;

    function automatic void clear_line();
        line_xor    = 8'h00;
        star_hit    = 1'b0;
        digit_count = 2'd0;
        given_sum   = 8'h00;
        char_count  = 0;
    endfunction

    // Hex digit decode: fold to lower case first; anything not a digit is zero
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] low;
        low = c | 8'h20;
        if (c >= "0" && c <= "9") begin
            return c[3:0];
        end
        if (low >= "a" && low <= "f") begin
            return c[3:0] + 4'd9;
        end
        return 4'd0;
    endfunction

    // Advances the predictor by one byte; returns 1 when the byte ends a line
    function automatic bit line_step(input logic [7:0] c, output result_t res);
        res = '0;
        if (c == CHAR_DOLLAR) begin
            return 1'b0;
        end
        if (c == CHAR_CR || c == CHAR_LF) begin
            res.sentence_length = char_count[OUT_LEN_W-1:0];
            if (char_count != 0) begin
                res.checksum_ok = star_hit && digit_count == 2'd2 && given_sum == line_xor;
                if (!res.checksum_ok && bad_lines != FAIL_TOP) begin
                    bad_lines++;
                end
            end
            res.fail_count = bad_lines;
            clear_line();
            return 1'b1;
        end
        // a byte landing on a full line starts a fresh one
        if (char_count >= LINE_MAX) begin
            clear_line();
        end
        char_count++;
        if (char_count > longest_line) begin
            longest_line = char_count;
        end
        if (!star_hit) begin
            if (c == CHAR_STAR) begin
                star_hit = 1'b1;
            end else begin
                line_xor ^= c;
            end
        end else if (digit_count < 2'd2) begin
            given_sum = {given_sum[3:0], nibble_of(c)};
            digit_count++;
        end
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------
    // Clock, watchdog and monitors
    // ---------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    int unsigned quiet_cycles;
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Input side: every accepted byte goes through the predictor
    always @(posedge aclk) begin : take_byte
        beat_t   note;
        result_t res;
        if (aresetn && s_tvalid && s_tready) begin
            note = beat_notes.pop_front();
            if (line_step(s_tdata, res)) begin
                // a hand-typed result stands in for the prediction on directed rows
                pending_lines.push_back(note.known ? note.want : res);
            end
        end
    end

    // Result side: field-by-field compare against the oldest expectation
    always @(posedge aclk) begin : check_line
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[RES_W-1:0];
            lines_checked++;
            if (pending_lines.size() == 0) begin
                $error("line result with none expected: %h", m_tdata);
                errors++;
            end else begin
                want = pending_lines.pop_front();
                if (got.checksum_ok !== want.checksum_ok) begin
                    $error("checksum_ok: expected %0d, got %0d",
                           want.checksum_ok, got.checksum_ok);
                    errors++;
                end
                if (got.sentence_length !== want.sentence_length) begin
                    $error("sentence_length: expected %0d, got %0d",
                           want.sentence_length, got.sentence_length);
                    errors++;
                end
                if (got.fail_count !== want.fail_count) begin
                    $error("fail_count: expected %0d, got %0d",
                           want.fail_count, got.fail_count);
                    errors++;
                end
                if (m_tdata[TDATA_W-1:RES_W] !== '0) begin
                    $error("tdata padding: expected 0, got %h", m_tdata[TDATA_W-1:RES_W]);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stall bursts, or one long hold-off when asked for.
    // Only one assignment to m_tready per edge.
    initial begin
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold = 1'b0;
                m_tready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------
    task automatic drive_byte(input beat_t note);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        beat_notes.push_back(note);
        s_tvalid <= 1'b1;
        s_tdata  <= note.c;
        bytes_sent++;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    function automatic beat_t step_plain(input logic [7:0] c);
        beat_t b;
        b = '0;
        b.c = c;
        return b;
    endfunction

    function automatic beat_t step_known(input logic [7:0] c, input logic ok,
                                         input int unsigned len, input int unsigned fails);
        beat_t b;
        b.c = c;
        b.known = 1'b1;
        b.want.checksum_ok = ok;
        b.want.sentence_length = len[OUT_LEN_W-1:0];
        b.want.fail_count = fails[FAIL_W-1:0];
        return b;
    endfunction

    task automatic put(input logic [7:0] c);
        drive_byte(step_plain(c));
    endtask

    // A body byte: anything but the line ends, the star and the dollar
    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CHAR_CR || c == CHAR_LF || c == CHAR_STAR || c == CHAR_DOLLAR);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + 8'(n);
        end
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    task automatic end_line();
        case ($urandom_range(0, 2))
            0: put(CHAR_CR);
            1: put(CHAR_LF);
            default: begin
                put(CHAR_CR);
                put(CHAR_LF);   // CR LF: the LF closes an empty line
            end
        endcase
    endtask

    // the last accepted byte is only booked by the monitor at that edge
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_lines.size() != 0) @(posedge aclk);
    endtask

    // Mostly well-formed sentences; one in five carries a flaw
    task automatic send_sentence();
        logic [7:0]  body_sum;
        logic [7:0]  c;
        int unsigned body_len;
        int unsigned flaw;
        body_sum = 8'h00;
        if ($urandom_range(0, 9) != 0) begin
            put(CHAR_DOLLAR);
        end
        // a few lines right at and past the buffer bound, spread through the run
        if (long_lines < 3 && bytes_sent >= (long_lines + 1) * 400) begin
            case (long_lines)
                0: body_len = LINE_MAX - 3;      // exactly LINE_MAX with star and digits
                1: body_len = LINE_MAX - 2;      // one byte over
                default: body_len = LINE_MAX - 3 + $urandom_range(2, 40);
            endcase
            long_lines++;
        end else begin
            body_len = $urandom_range(0, 20);
        end
        repeat (body_len) begin
            if ($urandom_range(0, 24) == 0) begin
                put(CHAR_DOLLAR);   // stray dollar, dropped mid-line
            end
            c = plain_byte();
            body_sum ^= c;
            put(c);
        end
        flaw = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
        case (flaw)
            0: begin
                put(CHAR_STAR);
                put(hex_char(body_sum[7:4]));
                put(hex_char(body_sum[3:0]));
            end
            1: ;                                  // star missing
            2: begin
                put(CHAR_STAR);
                put(hex_char(body_sum[7:4]));     // one digit short
            end
            3: begin
                body_sum ^= 8'($urandom_range(1, 255));
                put(CHAR_STAR);
                put(hex_char(body_sum[7:4]));
                put(hex_char(body_sum[3:0]));
            end
            default: begin
                put(CHAR_STAR);
                put(hex_char(body_sum[7:4]));
                put(plain_byte());                // likely not a hex digit
            end
        endcase
        // trailing bytes after the digits still count in the length
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                put($urandom_range(0, 3) == 0 ? CHAR_STAR : plain_byte());
            end
        end
        end_line();
        sentences++;
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8)) begin
            put(8'($urandom_range(0, 255)));
        end
    endtask

    // One random step of the mixed traffic, with the stall tests dropped in
    task automatic random_step();
        if (gaps_on && (sentences == 25 || sentences == 100)) begin
            // receiver holds off while empty lines pile up: buffer fills, input stalls
            long_hold = 1'b1;
            repeat (5) put(CHAR_CR);
        end
        if ($urandom_range(0, 9) == 0) begin
            send_noise();
        end else begin
            send_sentence();
        end
        if (sentences % 40 == 0) begin
            drain();
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    beat_t script[$];

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        clear_line();
        bad_lines    = '0;
        longest_line = 0;
        errors       = 0;
        gaps_on      = 1'b1;
        long_hold    = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: empty lines, a good sentence, lower-case digits on high
        // bytes with trailing data, too few digits, no star, non-hex digit as zero
        script = '{
            step_known(CHAR_CR, 1'b0, 0, 0),
            step_known(CHAR_LF, 1'b0, 0, 0),
            step_plain(CHAR_DOLLAR), step_plain("A"), step_plain(CHAR_STAR),
            step_plain("4"), step_plain("1"),
            step_known(CHAR_CR, 1'b1, 4, 0),
            step_plain(CHAR_DOLLAR), step_plain(8'hFF), step_plain(CHAR_STAR),
            step_plain("f"), step_plain("f"), step_plain(8'h80),
            step_plain(CHAR_LF),
            step_plain("B"), step_plain(CHAR_STAR), step_plain("4"),
            step_known(CHAR_CR, 1'b0, 3, 1),
            step_plain("Z"),
            step_known(CHAR_LF, 1'b0, 1, 2),
            step_plain(8'h00), step_plain(CHAR_STAR), step_plain("0"), step_plain("g"),
            step_plain(CHAR_CR)
        };
        foreach (script[i]) begin
            drive_byte(script[i]);
        end
        drain();

        // Random traffic with idling on both sides
        while (bytes_sent < RANDOM_ITEMS) begin
            random_step();
        end
        drain();

        // Closing stretch at full rate, no idling on either side
        gaps_on = 1'b0;
        while (bytes_sent < RANDOM_ITEMS + CLOSING_ITEMS) begin
            random_step();
        end
        drain();
        repeat (8) @(posedge aclk);

        $display("Sent %0d bytes in %0d sentences, %0d line results checked.",
                 bytes_sent, sentences, lines_checked);
        $display("Longest line %0d bytes, %0d lines at the bound, failure tally %0d.",
                 longest_line, long_lines, bad_lines);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
sv/nscv_pkg.sv
sv/nscv_line_check.sv
sv/nscv_out_buf.sv
sv/nmea_sentence_checksum_verifier.sv
bench/nmea_sentence_checksum_verifier_test.sv
